/* rtl/stq_pkg.sv */
// stq_pkg: shared types and constants of the sorted timer queue
// no dependencies; imported by the controller, datapath, top level and testbench
package stq_pkg;

  localparam logic       FUNC_INSERT = 1'b0;
  localparam logic       FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic [31:0] TPS_RESET  = 32'd62500000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;   // capture the accepted input item
    logic mul;     // ticks_per_second * wait_seconds
    logic add;     // deadline = now_count + product
    logic cmp;     // per-cell deadline compare
    logic apply;   // shift the cells, update occupancy
    logic load;    // load the output register
  } cmd_t;

endpackage

/* rtl/stq_ctrl.sv */
// stq_ctrl: sequencer of the sorted timer queue
// depends on stq_pkg; drives cmd_t towards stq_datapath
module stq_ctrl
  import stq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_func,
  output logic in_ready,
  input  logic out_busy,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_CMP,
    S_APPLY,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r, rdy_nxt;
  logic   accept;

  assign accept   = in_valid && rdy_r;
  assign in_ready = rdy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          // a remove needs no deadline
          state_nxt = (in_func == FUNC_REMOVE) ? S_APPLY : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rdy_nxt = (state_nxt == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

endmodule

/* rtl/stq_datapath.sv */
// stq_datapath: deadline arithmetic, sorted cell row and output register
// depends on stq_pkg; sequenced by stq_ctrl through cmd_t
module stq_datapath
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8,
  localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  logic                in_func,
  input  logic [TAG_BITS-1:0] in_tag,
  input  logic [31:0]         in_wait,
  input  logic [63:0]         in_now,
  input  logic                out_ready,
  output logic                out_busy,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic                out_head_valid,
  output logic [63:0]         out_head_deadline,
  output logic [TAG_BITS-1:0] out_head_tag,
  output logic [TAG_BITS-1:0] out_removed_tag,
  output logic [OCC_W-1:0]    out_entry_count
);

  logic [31:0]         tps_r;
  logic                func_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [31:0]         wait_r;
  logic [63:0]         now_r;
  logic [63:0]         prod_r;
  logic [63:0]         deadline_r;
  logic [QUEUE_DEPTH-1:0] ge_r, ge_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [1:0]          st_r, st_nxt;
  logic [TAG_BITS-1:0] rem_r, rem_nxt;

  logic [63:0]         dl_r    [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tg_r    [QUEUE_DEPTH];
  logic [63:0]         dl_nxt  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tg_nxt  [QUEUE_DEPTH];
  logic [63:0]         dl_below[QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tg_below[QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] ge_ext;

  logic full, empty, op_ok;
  logic out_valid_r;
  logic [1:0]          o_st_r;
  logic                o_hv_r;
  logic [63:0]         o_hd_r;
  logic [TAG_BITS-1:0] o_ht_r;
  logic [TAG_BITS-1:0] o_rt_r;
  logic [OCC_W-1:0]    o_cnt_r;

  assign full  = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign empty = (occ_r == '0);
  assign op_ok = (func_r == FUNC_INSERT) ? !full : !empty;

  // parallel compare: cell holds a live deadline not later than the new one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge_nxt[i] = (OCC_W'(i) < occ_r) && (deadline_r >= dl_r[i]);
    end
  end

  // neighbour below each cell; cell 0 sees the new timer
  always_comb begin
    dl_below[0] = deadline_r;
    tg_below[0] = tag_r;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      dl_below[i] = dl_r[i-1];
      tg_below[i] = tg_r[i-1];
    end
  end

  assign ge_ext = {ge_r, 1'b1};

  always_comb begin
    dl_nxt  = dl_r;
    tg_nxt  = tg_r;
    occ_nxt = occ_r;
    st_nxt  = ST_OK;
    rem_nxt = '0;
    if (func_r == FUNC_INSERT) begin
      if (full) st_nxt = ST_FULL;
    end else begin
      if (empty) st_nxt = ST_EMPTY;
    end
    if (cmd.apply && op_ok) begin
      if (func_r == FUNC_REMOVE) begin
        rem_nxt = tg_r[0];
        occ_nxt = occ_r - 1'b1;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          dl_nxt[i] = dl_r[i+1];
          tg_nxt[i] = tg_r[i+1];
        end
      end else begin
        occ_nxt = occ_r + 1'b1;
        // cells at or before an equal deadline stay, the first later one
        // takes the new timer, the rest move up by one
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!ge_r[i]) begin
            dl_nxt[i] = ge_ext[i] ? deadline_r : dl_below[i];
            tg_nxt[i] = ge_ext[i] ? tag_r      : tg_below[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      tag_r  <= in_tag;
      wait_r <= in_wait;
      now_r  <= in_now;
    end
    if (cmd.mul) prod_r <= 64'(tps_r) * 64'(wait_r);
    if (cmd.add) deadline_r <= now_r + prod_r;
    if (cmd.cmp) ge_r <= ge_nxt;
    if (cmd.apply) begin
      st_r  <= st_nxt;
      rem_r <= rem_nxt;
    end
    dl_r <= dl_nxt;
    tg_r <= tg_nxt;
    if (cmd.load) begin
      o_st_r  <= st_r;
      o_hv_r  <= !empty;
      o_hd_r  <= empty ? 64'd0 : dl_r[0];
      o_ht_r  <= empty ? '0 : tg_r[0];
      o_rt_r  <= rem_r;
      o_cnt_r <= occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= TPS_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) tps_r <= cfg_data;
      occ_r <= occ_nxt;
      if (cmd.load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_busy          = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = o_st_r;
  assign out_head_valid    = o_hv_r;
  assign out_head_deadline = o_hd_r;
  assign out_head_tag      = o_ht_r;
  assign out_removed_tag   = o_rt_r;
  assign out_entry_count   = o_cnt_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && op_ok && (func_r == FUNC_INSERT) |=>
      occ_r == OCC_W'($past(occ_r) + 1'b1))
    else $error("insert did not grow the queue by one");

  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_hv_r == (o_cnt_r != '0)))
    else $error("head valid disagrees with entry count");

  a_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && !op_ok |=> occ_r == $past(occ_r))
    else $error("dropped step changed occupancy");

endmodule

/* rtl/sorted_timer_deadline_queue_unit.sv */
// sorted_timer_deadline_queue_unit: top level of the sorted timer queue
// depends on stq_pkg, stq_ctrl and stq_datapath
//
// Usage:
//   in_*  : one transfer is one step. in_tuser = func (0 insert, 1 remove);
//           in_tdata carries tag, wait_seconds and now_count.
//   out_* : one result per step, describing the queue after the step.
//   cfg_* : write of ticks_per_second; cfg_ready is always high. Write only
//           while no step is in flight.
// Steps: an insert runs through multiply, add, compare and shift stages;
//   the next item is taken only after its result has been loaded into the
//   output register. A remove skips the arithmetic. The 32x32 multiplier,
//   the 64-bit adder and the per-cell deadline compare are each registered.
// Reset: queue empty, ticks_per_second = 62500000, no result pending.
// Stall: the result waits in the output register; a following item is still
//   accepted and computed, and is held back only at its final load until
//   the earlier result has been transferred.
module sorted_timer_deadline_queue_unit
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8,
  localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_BITS    = TAG_BITS + 96,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 67 + 2 * TAG_BITS + OCC_W,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // fields from bit 0: tag, wait_seconds, now_count, zero padding
  input  logic [IN_W-1:0]  in_tdata,
  // fields from bit 0: func
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // fields from bit 0: status, head_valid, head_deadline, head_tag,
  // removed_tag, entry_count, zero padding
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  cmd_t                cmd;
  logic                out_busy;
  logic [1:0]          status;
  logic                head_valid;
  logic [63:0]         head_deadline;
  logic [TAG_BITS-1:0] head_tag;
  logic [TAG_BITS-1:0] removed_tag;
  logic [OCC_W-1:0]    entry_count;

  assign cfg_ready = 1'b1;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_ready (in_tready),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  stq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid),
    .cfg_data          (cfg_data),
    .in_func           (in_tuser),
    .in_tag            (in_tdata[TAG_BITS-1:0]),
    .in_wait           (in_tdata[TAG_BITS+31:TAG_BITS]),
    .in_now            (in_tdata[TAG_BITS+95:TAG_BITS+32]),
    .out_ready         (out_tready),
    .out_busy          (out_busy),
    .out_valid         (out_tvalid),
    .out_status        (status),
    .out_head_valid    (head_valid),
    .out_head_deadline (head_deadline),
    .out_head_tag      (head_tag),
    .out_removed_tag   (removed_tag),
    .out_entry_count   (entry_count)
  );

  assign out_tdata = OUT_W'({entry_count, removed_tag, head_tag,
                             head_deadline, head_valid, status});

endmodule

/* dv/tb_sorted_timer_deadline_queue_unit.sv */
`timescale 1ns / 1ps
// tb_sorted_timer_deadline_queue_unit: self-checking bench for the sorted timer queue
// drives steps and ticks_per_second writes, checks every result against a software
// queue or a typed row's preset; depends on stq_pkg and sorted_timer_deadline_queue_unit
module tb_sorted_timer_deadline_queue_unit;
  import stq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int IN_W       = 104;
  localparam int OUT_W      = 88;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_PHASES   = 5;

  // declared msb first so that it overlays out_tdata directly
  typedef struct packed {
    logic [4:0]  entry_count;
    logic [7:0]  removed_tag;
    logic [7:0]  head_tag;
    logic [63:0] head_deadline;
    logic        head_valid;
    logic [1:0]  status;
  } timer_result_t;

  typedef struct {
    logic          func;
    logic [7:0]    tag;
    logic [31:0]   wait_secs;
    logic [63:0]   now_cnt;
    bit            typed;
    timer_result_t res;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [31:0]      cfg_data;

  sorted_timer_deadline_queue_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // software copy of the timer queue
  logic [63:0]   held_deadline [DEPTH];
  logic [7:0]    held_tag [DEPTH];
  int            held_count;
  logic [31:0]   tps_model;
  timer_result_t pending_results [$];

  int            mismatches;
  bit            idle_on;
  logic [63:0]   now_base;
  int            quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic timer_result_t mk_res(input logic [1:0] status, input logic hv,
                                           input logic [63:0] dl, input logic [7:0] htag,
                                           input logic [7:0] rtag, input logic [4:0] cnt);
    timer_result_t r;
    r.status        = status;
    r.head_valid    = hv;
    r.head_deadline = dl;
    r.head_tag      = htag;
    r.removed_tag   = rtag;
    r.entry_count   = cnt;
    return r;
  endfunction

  function automatic timer_result_t advance_timer_queue(input logic func, input logic [7:0] tag,
                                                        input logic [31:0] wait_secs,
                                                        input logic [63:0] now_cnt);
    timer_result_t r;
    logic [63:0]   dl;
    logic [7:0]    taken;
    logic [1:0]    status;
    int            pos;
    int            i;
    status = ST_OK;
    taken  = '0;
    if (func == FUNC_INSERT) begin
      if (held_count >= DEPTH) begin
        status = ST_FULL;
      end else begin
        dl  = now_cnt + {32'b0, tps_model} * {32'b0, wait_secs};
        pos = 0;
        // equal deadlines stay in arrival order
        while (pos < held_count && dl >= held_deadline[pos]) pos++;
        for (i = held_count; i > pos; i--) begin
          held_deadline[i] = held_deadline[i-1];
          held_tag[i]      = held_tag[i-1];
        end
        held_deadline[pos] = dl;
        held_tag[pos]      = tag;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        status = ST_EMPTY;
      end else begin
        taken = held_tag[0];
        for (i = 1; i < held_count; i++) begin
          held_deadline[i-1] = held_deadline[i];
          held_tag[i-1]      = held_tag[i];
        end
        held_count--;
      end
    end
    r = mk_res(status, held_count > 0, (held_count > 0) ? held_deadline[0] : 64'd0,
               (held_count > 0) ? held_tag[0] : 8'd0, taken, held_count[4:0]);
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic func, input logic [7:0] tag,
                                       input logic [31:0] wait_secs, input logic [63:0] now_cnt);
    stim_row_t r;
    r.func      = func;
    r.tag       = tag;
    r.wait_secs = wait_secs;
    r.now_cnt   = now_cnt;
    r.typed     = 1'b0;
    r.res       = '0;
    return r;
  endfunction

  function automatic stim_row_t random_row(input int insert_pct);
    stim_row_t   r;
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: w = $urandom_range(0, 20);
      5, 6, 7:       w = $urandom;
      8:             w = 32'hFFFF_FFFF;
      default:       w = 32'd0;
    endcase
    // counter often runs forward; sometimes it stands still so deadlines tie
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3:       now_base = {$urandom, $urandom};
      4:       now_base = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 50);
      default: now_base = now_base + $urandom_range(1, 5000);
    endcase
    r = mk_row(($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_REMOVE,
               $urandom_range(0, 255), w, now_base);
    return r;
  endfunction

  task automatic send_step(input stim_row_t r);
    timer_result_t p;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.func;
    in_tdata  <= {r.now_cnt, r.wait_secs, r.tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = advance_timer_queue(r.func, r.tag, r.wait_secs, r.now_cnt);
    pending_results.push_back(r.typed ? r.res : p);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_tps(input logic [31:0] value);
    drain_results();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tps_model = value;
    cfg_valid <= 1'b0;
  endtask

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = timer_result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d hv=%0b dl=%h ht=%h rt=%h cnt=%0d",
                   got.status, got.head_valid, got.head_deadline, got.head_tag,
                   got.removed_tag, got.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: st=%0d hv=%0b dl=%h ht=%h rt=%h cnt=%0d",
                     want.status, want.head_valid, want.head_deadline, want.head_tag,
                     want.removed_tag, want.entry_count);
            $display("         got: st=%0d hv=%0b dl=%h ht=%h rt=%h cnt=%0d",
                     got.status, got.head_valid, got.head_deadline, got.head_tag,
                     got.removed_tag, got.entry_count);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t   rows [$];
    stim_row_t   r;
    logic [31:0] tps_plan [N_PHASES];
    int          insert_plan [N_PHASES];
    int          count_plan [N_PHASES];
    int          ph;
    int          k;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= FUNC_INSERT;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    mismatches = 0;
    quiet_cycles = 0;
    idle_on    = 1'b1;
    now_base   = 64'd1000;
    held_count = 0;
    tps_model  = TPS_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: empty queue, wrap-around, ties, full queue
    r = mk_row(FUNC_REMOVE, 8'h00, 32'd0, 64'd0);
    r.typed = 1'b1;
    r.res = mk_res(ST_EMPTY, 1'b0, 64'd0, 8'h00, 8'h00, 5'd0);
    rows.push_back(r);
    r = mk_row(FUNC_INSERT, 8'hFF, 32'd0, 64'd0);
    r.typed = 1'b1;
    r.res = mk_res(ST_OK, 1'b1, 64'd0, 8'hFF, 8'h00, 5'd1);
    rows.push_back(r);
    r = mk_row(FUNC_REMOVE, 8'h00, 32'd0, 64'd0);
    r.typed = 1'b1;
    r.res = mk_res(ST_OK, 1'b0, 64'd0, 8'h00, 8'hFF, 5'd0);
    rows.push_back(r);
    rows.push_back(mk_row(FUNC_INSERT, 8'h00, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    rows.push_back(mk_row(FUNC_INSERT, 8'h01, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    // same deadline reached two ways
    rows.push_back(mk_row(FUNC_INSERT, 8'h02, 32'd1, 64'd100));
    rows.push_back(mk_row(FUNC_INSERT, 8'h03, 32'd0, 64'd100 + TPS_RESET));
    for (k = 0; k < 12; k++)
      rows.push_back(mk_row(FUNC_INSERT, 8'h10 + k, k % 3, k * 97));
    rows.push_back(mk_row(FUNC_INSERT, 8'hAA, 32'd5, 64'd5));
    rows.push_back(mk_row(FUNC_REMOVE, 8'h55, 32'd7, 64'd9));
    foreach (rows[i]) send_step(rows[i]);

    tps_plan    = '{32'd1, 32'hFFFF_FFFF, $urandom_range(2, 32'hFFFF_FFFE), TPS_RESET,
                    $urandom_range(1, 32'hFFFF_FFFF)};
    insert_plan = '{75, 35, 60, 50, 55};
    count_plan  = '{220, 220, 220, 220, 200};
    for (ph = 0; ph < N_PHASES; ph++) begin
      write_tps(tps_plan[ph]);
      // last stretch runs at full rate on both sides
      if (ph == N_PHASES - 1) idle_on = 1'b0;
      for (k = 0; k < count_plan[ph]; k++) send_step(random_row(insert_plan[ph]));
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/stq_pkg.sv
rtl/stq_ctrl.sv
rtl/stq_datapath.sv
rtl/sorted_timer_deadline_queue_unit.sv
dv/tb_sorted_timer_deadline_queue_unit.sv
